// ===== src/vac_pkg.sv =====
package vac_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DATA_TYPE = 2'd0;
    localparam logic [1:0] REG_NORMALIZE = 2'd1;
    localparam logic [1:0] REG_COUNT     = 2'd2;
    localparam logic [1:0] REG_KIND      = 2'd3;

    // Source data types
    localparam logic [2:0] DT_FLOAT  = 3'd0;
    localparam logic [2:0] DT_BYTE   = 3'd1;
    localparam logic [2:0] DT_UBYTE  = 3'd2;
    localparam logic [2:0] DT_SHORT  = 3'd3;
    localparam logic [2:0] DT_USHORT = 3'd4;

    // Attribute kinds
    localparam logic [2:0] KIND_POSITION = 3'd0;
    localparam logic [2:0] KIND_TEXCOORD = 3'd1;
    localparam logic [2:0] KIND_NORMAL   = 3'd2;
    localparam logic [2:0] KIND_COLOUR   = 3'd3;
    localparam logic [2:0] KIND_WEIGHT   = 3'd4;
    localparam logic [2:0] KIND_BONE     = 3'd5;

    localparam int NUM_LANES = 4;
    localparam int CFG_W     = 3;

    localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;
    localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] data_type;
        logic       normalize;
        logic [2:0] component_count;
        logic [2:0] attribute_kind;
    } cfg_t;

    // Exact integer to float for magnitudes up to 16 bits
    function automatic logic [31:0] int_to_float(input logic sign, input logic [15:0] mag);
        logic [3:0]  p;
        logic [23:0] m;
        logic [7:0]  e;
        p = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (mag[i])
            begin
                p = 4'(i);
            end
        end
        m = {8'b0, mag} << (5'd23 - {1'b0, p});
        e = 8'd127 + {4'b0, p};
        if (mag == 16'd0)
        begin
            int_to_float = 32'd0;
        end
        else
        begin
            int_to_float = {sign, e, m[22:0]};
        end
    endfunction

    // v / 255 rounded to nearest; the quotient's binary expansion repeats v
    function automatic logic [31:0] div255(input logic [7:0] v);
        logic [2:0]  p;
        logic [39:0] r;
        logic [7:0]  e;
        p = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                p = 3'(i);
            end
        end
        r = {v, v, v, v, v} << (3'd7 - p);
        e = 8'd119 + {5'b0, p};
        if (v == 8'd0)
        begin
            div255 = 32'd0;
        end
        else if (v == 8'hFF)
        begin
            div255 = FLOAT_ONE;
        end
        else
        begin
            div255 = {1'b0, e, r[38:16]} + {31'b0, r[15]};
        end
    endfunction

    // Divide by 512, rounding subnormal results to nearest even
    function automatic logic [31:0] tex_scale(input logic [31:0] b);
        logic [7:0]  e;
        logic [23:0] sig;
        logic [3:0]  sh;
        logic [33:0] w;
        logic        rnd;
        e   = b[30:23];
        sig = {e != 8'd0, b[22:0]};
        sh  = (e == 8'd0) ? 4'd9 : 4'(8'd10 - e);
        w   = {sig, 10'b0} >> sh;
        rnd = w[9] && ((|w[8:0]) || w[10]);
        if (e == 8'hFF)
        begin
            tex_scale = (b[22:0] != 23'd0) ? (b | 32'h0040_0000) : b;
        end
        else if (e > 8'd10)
        begin
            tex_scale = {b[31], e - 8'd9, b[22:0]};
        end
        else
        begin
            tex_scale = {b[31], 31'(w[33:10]) + {30'b0, rnd}};
        end
    endfunction

    // Truncate toward zero to int32 with saturation; NaN gives zero
    function automatic logic [31:0] trunc_index(input logic [31:0] b);
        logic [7:0]  e;
        logic [31:0] sig;
        logic [31:0] mag;
        e   = b[30:23];
        sig = {8'b0, 1'b1, b[22:0]};
        if (e >= 8'd150)
        begin
            mag = sig << 3'(e - 8'd150);
        end
        else
        begin
            mag = sig >> 5'(8'd150 - e);
        end
        if (e == 8'hFF && b[22:0] != 23'd0)
        begin
            trunc_index = 32'd0;
        end
        else if (e >= 8'd158)
        begin
            trunc_index = b[31] ? INT_MIN : INT_MAX;
        end
        else if (e < 8'd127)
        begin
            trunc_index = 32'd0;
        end
        else
        begin
            trunc_index = b[31] ? (~mag + 32'd1) : mag;
        end
    endfunction

endpackage

// ===== src/vac_in_if.sv =====
interface vac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_comp_0;
    logic [31:0] raw_comp_1;
    logic [31:0] raw_comp_2;
    logic [31:0] raw_comp_3;
    logic        last_vertex;

    modport source (output valid, raw_comp_0, raw_comp_1, raw_comp_2, raw_comp_3,
                    last_vertex, input ready);
    modport sink (input valid, raw_comp_0, raw_comp_1, raw_comp_2, raw_comp_3,
                  last_vertex, output ready);
endinterface

// ===== src/vac_out_if.sv =====
interface vac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_0;
    logic [31:0] value_1;
    logic [31:0] value_2;
    logic [31:0] value_3;
    logic [31:0] packed_index;
    logic        last_out;

    modport source (output valid, value_0, value_1, value_2, value_3, packed_index,
                    last_out, input ready);
    modport sink (input valid, value_0, value_1, value_2, value_3, packed_index,
                  last_out, output ready);
endinterface

// ===== src/vac_lane.sv =====
module vac_lane
(
    input  logic          clk,
    input  logic          en1,
    input  logic          en2,
    input  vac_pkg::cfg_t cfg,
    input  logic          active,
    input  logic [31:0]   raw,
    output logic [31:0]   comp,
    output logic [31:0]   tex,
    output logic [31:0]   trunc
);

    logic [31:0] conv;
    logic [31:0] ifl;
    logic [15:0] mag;
    logic        sgn;
    logic [7:0]  norm_shift;
    logic [31:0] c_reg;
    logic [31:0] comp_reg;
    logic [31:0] tex_reg;
    logic [31:0] trunc_reg;

    // Convert the raw word to float bits
    always_comb
    begin
        sgn        = 1'b0;
        mag        = 16'd0;
        norm_shift = 8'd0;
        case (cfg.data_type)
            vac_pkg::DT_BYTE:
            begin
                sgn        = raw[7];
                mag        = raw[7] ? 16'(~{8'hFF, raw[7:0]} + 16'd1) : {8'b0, raw[7:0]};
                norm_shift = 8'd7;
            end
            vac_pkg::DT_UBYTE:
            begin
                mag = {8'b0, raw[7:0]};
            end
            vac_pkg::DT_SHORT:
            begin
                sgn        = raw[15];
                mag        = raw[15] ? (~raw[15:0] + 16'd1) : raw[15:0];
                norm_shift = 8'd15;
            end
            vac_pkg::DT_USHORT:
            begin
                mag        = raw[15:0];
                norm_shift = 8'd16;
            end
            default:
            begin
                mag = 16'd0;
            end
        endcase
        ifl = vac_pkg::int_to_float(sgn, mag);
        case (cfg.data_type)
            vac_pkg::DT_FLOAT:
            begin
                conv = raw;
            end
            vac_pkg::DT_BYTE, vac_pkg::DT_SHORT, vac_pkg::DT_USHORT:
            begin
                conv = ifl;
                if (cfg.normalize && mag != 16'd0)
                begin
                    conv = {ifl[31], ifl[30:23] - norm_shift, ifl[22:0]};
                end
            end
            vac_pkg::DT_UBYTE:
            begin
                conv = cfg.normalize ? vac_pkg::div255(raw[7:0]) : ifl;
            end
            default:
            begin
                conv = 32'd0;
            end
        endcase
    end

    // Stage one: hold the converted component
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            c_reg <= active ? conv : 32'd0;
        end
    end

    // Stage two: texcoord scale and index truncation
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            comp_reg  <= c_reg;
            tex_reg   <= vac_pkg::tex_scale(c_reg);
            trunc_reg <= vac_pkg::trunc_index(c_reg);
        end
    end

    assign comp  = comp_reg;
    assign tex   = tex_reg;
    assign trunc = trunc_reg;

endmodule

// ===== src/vac_merge.sv =====
module vac_merge
(
    input  logic        clk,
    input  logic        en,
    input  logic [2:0]  kind,
    input  logic [31:0] comp [vac_pkg::NUM_LANES],
    input  logic [31:0] tex [vac_pkg::NUM_LANES],
    input  logic [31:0] trunc [vac_pkg::NUM_LANES],
    output logic [31:0] value [vac_pkg::NUM_LANES],
    output logic [31:0] packed_index
);

    logic [31:0] val_next [vac_pkg::NUM_LANES];
    logic [31:0] pk_next;
    logic [31:0] val_reg [vac_pkg::NUM_LANES];
    logic [31:0] pk_reg;

    // Pick the values the kind asks for
    always_comb
    begin
        for (int i = 0; i < vac_pkg::NUM_LANES; i++)
        begin
            val_next[i] = 32'd0;
        end
        pk_next = 32'd0;
        case (kind)
            vac_pkg::KIND_POSITION, vac_pkg::KIND_NORMAL:
            begin
                val_next[0] = comp[0];
                val_next[1] = comp[1];
                val_next[2] = comp[2];
            end
            vac_pkg::KIND_TEXCOORD:
            begin
                val_next[0] = tex[0];
                val_next[1] = tex[1];
            end
            vac_pkg::KIND_COLOUR, vac_pkg::KIND_WEIGHT:
            begin
                for (int i = 0; i < vac_pkg::NUM_LANES; i++)
                begin
                    val_next[i] = comp[i];
                end
            end
            vac_pkg::KIND_BONE:
            begin
                pk_next = (trunc[3] << 24) | (trunc[2] << 16) | (trunc[1] << 8) | trunc[0];
            end
            default:
            begin
                pk_next = 32'd0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            pk_reg  <= pk_next;
        end
    end

    assign value        = val_reg;
    assign packed_index = pk_reg;

endmodule

// ===== src/vertex_attribute_converter.sv =====
// Vertex attribute converter.
// attr_in carries one vertex's four raw components and a last flag; attr_out
// gives up to four IEEE single values and a packed bone-index word, with the
// last flag echoed. Both use valid/ready; a word moves when both are high.
// The configuration port (cfg_we, cfg_index, cfg_wdata) sets data type,
// normalize, component count and attribute kind; write it only while idle.
// Four lanes convert the components in parallel through a three-stage
// pipeline: conversion, texcoord scale and truncation, then the merge
// register. An accepted vertex moves through these stages in order, and
// attr_out.valid rises once it is held in the merge register.
// Throughput is one vertex per cycle while attr_out.ready stays high.
// When the receiver stalls, each stage holds its word and attr_in.ready
// drops only once every stage is full, so up to three vertices are held.
// Reset empties the pipeline and loads the registers with float source,
// no normalize, four components and position kind.
module vertex_attribute_converter
(
    input  logic                       clk,
    input  logic                       rst_n,
    vac_in_if.sink                     attr_in,
    vac_out_if.source                  attr_out,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [vac_pkg::CFG_W-1:0]  cfg_wdata
);

    vac_pkg::cfg_t cfg_reg;
    logic          v1_reg, v2_reg, v3_reg;
    logic          l1_reg, l2_reg, l3_reg;
    logic          adv1, adv2, adv3;
    logic [2:0]    count;
    logic [31:0]   raw [vac_pkg::NUM_LANES];
    logic [31:0]   comp [vac_pkg::NUM_LANES];
    logic [31:0]   tex [vac_pkg::NUM_LANES];
    logic [31:0]   trunc [vac_pkg::NUM_LANES];
    logic [31:0]   value [vac_pkg::NUM_LANES];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_type       <= vac_pkg::DT_FLOAT;
            cfg_reg.normalize       <= 1'b0;
            cfg_reg.component_count <= 3'd4;
            cfg_reg.attribute_kind  <= vac_pkg::KIND_POSITION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vac_pkg::REG_DATA_TYPE: cfg_reg.data_type       <= cfg_wdata;
                vac_pkg::REG_NORMALIZE: cfg_reg.normalize       <= cfg_wdata[0];
                vac_pkg::REG_COUNT:     cfg_reg.component_count <= cfg_wdata;
                vac_pkg::REG_KIND:      cfg_reg.attribute_kind  <= cfg_wdata;
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Advance a stage when the one after it can take its word
    assign adv3 = !v3_reg || attr_out.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign attr_in.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= attr_in.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Carry the last flag alongside
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            l1_reg <= attr_in.last_vertex;
        end
        if (adv2)
        begin
            l2_reg <= l1_reg;
        end
        if (adv3)
        begin
            l3_reg <= l2_reg;
        end
    end

    assign count  = (cfg_reg.component_count > 3'd4) ? 3'd4 : cfg_reg.component_count;
    assign raw[0] = attr_in.raw_comp_0;
    assign raw[1] = attr_in.raw_comp_1;
    assign raw[2] = attr_in.raw_comp_2;
    assign raw[3] = attr_in.raw_comp_3;

    for (genvar g = 0; g < vac_pkg::NUM_LANES; g++)
    begin : g_lane
        vac_lane u_lane
        (
            .clk    (clk),
            .en1    (adv1),
            .en2    (adv2),
            .cfg    (cfg_reg),
            .active (3'(g) < count),
            .raw    (raw[g]),
            .comp   (comp[g]),
            .tex    (tex[g]),
            .trunc  (trunc[g])
        );
    end

    vac_merge u_merge
    (
        .clk          (clk),
        .en           (adv3),
        .kind         (cfg_reg.attribute_kind),
        .comp         (comp),
        .tex          (tex),
        .trunc        (trunc),
        .value        (value),
        .packed_index (attr_out.packed_index)
    );

    assign attr_out.valid    = v3_reg;
    assign attr_out.value_0  = value[0];
    assign attr_out.value_1  = value[1];
    assign attr_out.value_2  = value[2];
    assign attr_out.value_3  = value[3];
    assign attr_out.last_out = l3_reg;

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        attr_in.valid && attr_in.ready |=> v1_reg)
        else $error("accepted word not held in stage one");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !attr_in.ready |-> v1_reg && v2_reg && v3_reg)
        else $error("input stalled with an empty stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !attr_out.ready |=> v3_reg && $stable(attr_out.packed_index))
        else $error("stalled output word lost");

    a_no_out_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !v3_reg |=> v3_reg)
        else $error("stage two word did not advance");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [3:0][31:0] vals;
        logic [31:0]      packed_word;
        logic             last;
    } vertex_result_t;

    typedef struct {
        logic [2:0]       dt;
        logic [2:0]       nm;
        logic [2:0]       cnt;
        logic [2:0]       kind;
        logic [3:0][31:0] raw;
        logic             last;
        bit               typed;
        vertex_result_t   res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [vac_pkg::CFG_W-1:0] cfg_wdata;

    vac_in_if  attr_in ();
    vac_out_if attr_out ();

    vertex_attribute_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .attr_in   (attr_in.sink),
        .attr_out  (attr_out.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the configuration registers
    logic [2:0] cur_type;
    logic       cur_norm;
    logic [2:0] cur_count;
    logic [2:0] cur_kind;

    vertex_result_t pending_vertices[$];
    stim_row_t      stim_rows[$];
    int error_count;
    int cycle_count;
    int send_idle;
    int recv_idle;

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Round a double to single precision, nearest even, subnormals included
    function automatic logic [31:0] round_to_single(real r);
        logic [63:0] d;
        logic [52:0] m;
        logic [53:0] kept;
        logic        halfb;
        logic        sticky;
        int          ue;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'd0)
        begin
            return {d[63], 31'd0};
        end
        ue = int'(d[62:52]) - 1023;
        m  = {1'b1, d[51:0]};
        sh = (ue >= -126) ? 29 : 29 + (-126 - ue);
        if (sh > 53)
        begin
            return {d[63], 31'd0};
        end
        kept   = 54'(m >> sh);
        halfb  = m[sh-1];
        sticky = (m & ((53'd1 << (sh - 1)) - 53'd1)) != 53'd0;
        if (halfb && (sticky || kept[0]))
        begin
            kept = kept + 54'd1;
        end
        if (ue >= -126)
        begin
            return {d[63], 31'((32'(ue + 126) << 23) + 32'(kept))};
        end
        return {d[63], 31'(kept)};
    endfunction

    // Widen finite single bits to a real
    function automatic real single_to_real(logic [31:0] b);
        real mag;
        if (b[30:23] == 8'd0)
        begin
            mag = real'(b[22:0]) * (2.0 ** (-149));
            return b[31] ? -mag : mag;
        end
        return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
    endfunction

    // Read one raw component as float bits under the current setting
    function automatic logic [31:0] component_bits(logic [31:0] raw);
        int  iv;
        real f;
        real den;
        case (cur_type)
            vac_pkg::DT_FLOAT:
                return raw;
            vac_pkg::DT_BYTE:
            begin
                iv  = raw[7] ? int'(raw[7:0]) - 256 : int'(raw[7:0]);
                den = 128.0;
            end
            vac_pkg::DT_UBYTE:
            begin
                iv  = int'(raw[7:0]);
                den = 255.0;
            end
            vac_pkg::DT_SHORT:
            begin
                iv  = raw[15] ? int'(raw[15:0]) - 65536 : int'(raw[15:0]);
                den = 32768.0;
            end
            vac_pkg::DT_USHORT:
            begin
                iv  = int'(raw[15:0]);
                den = 65536.0;
            end
            default:
                return 32'd0;
        endcase
        f = real'(iv);
        if (cur_norm)
        begin
            f = f / den;
        end
        return round_to_single(f);
    endfunction

    function automatic logic [31:0] texcoord_bits(logic [31:0] b);
        if (b[30:23] == 8'hFF)
        begin
            return (b[22:0] != 23'd0) ? (b | 32'h0040_0000) : b;
        end
        if (b[30:0] == 31'd0)
        begin
            return b;
        end
        return round_to_single(single_to_real(b) / 512.0);
    endfunction

    function automatic logic [31:0] bone_index(logic [31:0] b);
        if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
        begin
            return 32'd0;
        end
        if (b[30:23] >= 8'd158)
        begin
            return b[31] ? vac_pkg::INT_MIN : vac_pkg::INT_MAX;
        end
        return 32'($rtoi(single_to_real(b)));
    endfunction

    // Work out the result word for one vertex
    function automatic vertex_result_t convert_vertex(logic [3:0][31:0] raw, logic last);
        vertex_result_t   r;
        logic [3:0][31:0] c;
        int               n;
        n = (cur_count > 3'd4) ? 4 : int'(cur_count);
        for (int i = 0; i < 4; i++)
        begin
            c[i] = (i < n) ? component_bits(raw[i]) : 32'd0;
        end
        r.vals        = '0;
        r.packed_word = 32'd0;
        r.last        = last;
        case (cur_kind)
            vac_pkg::KIND_POSITION, vac_pkg::KIND_NORMAL:
            begin
                r.vals[0] = c[0];
                r.vals[1] = c[1];
                r.vals[2] = c[2];
            end
            vac_pkg::KIND_TEXCOORD:
            begin
                r.vals[0] = texcoord_bits(c[0]);
                r.vals[1] = texcoord_bits(c[1]);
            end
            vac_pkg::KIND_COLOUR, vac_pkg::KIND_WEIGHT:
                r.vals = c;
            vac_pkg::KIND_BONE:
                r.packed_word = (bone_index(c[3]) << 24) | (bone_index(c[2]) << 16)
                              | (bone_index(c[1]) << 8) | bone_index(c[0]);
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %08h, want %08h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Compare each delivered word with the oldest pending one
    always @(posedge clk)
    begin
        vertex_result_t want;
        if (rst_n && attr_out.valid && attr_out.ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("unexpected word", attr_out.value_0, 32'd0);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (attr_out.value_0 !== want.vals[0])
                    report_mismatch("value_0", attr_out.value_0, want.vals[0]);
                if (attr_out.value_1 !== want.vals[1])
                    report_mismatch("value_1", attr_out.value_1, want.vals[1]);
                if (attr_out.value_2 !== want.vals[2])
                    report_mismatch("value_2", attr_out.value_2, want.vals[2]);
                if (attr_out.value_3 !== want.vals[3])
                    report_mismatch("value_3", attr_out.value_3, want.vals[3]);
                if (attr_out.packed_index !== want.packed_word)
                    report_mismatch("packed_index", attr_out.packed_index, want.packed_word);
                if (attr_out.last_out !== want.last)
                    report_mismatch("last_out", 32'(attr_out.last_out), 32'(want.last));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            attr_out.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Drain, let the pipeline settle, then write all four registers
    task automatic apply_setup(logic [2:0] dt, logic [2:0] nm, logic [2:0] cnt,
                               logic [2:0] kind);
        attr_in.valid <= 1'b0;
        while (pending_vertices.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            case (2'(i))
                vac_pkg::REG_DATA_TYPE: cfg_wdata <= dt;
                vac_pkg::REG_NORMALIZE: cfg_wdata <= nm;
                vac_pkg::REG_COUNT:     cfg_wdata <= cnt;
                default:                cfg_wdata <= kind;
            endcase
            @(negedge clk);
        end
        cfg_we    <= 1'b0;
        cur_type  = dt;
        cur_norm  = nm[0];
        cur_count = cnt;
        cur_kind  = kind;
    endtask

    // Offer one word and hold it until taken
    task automatic send_vertex(logic [3:0][31:0] raw, logic last, vertex_result_t res);
        while ($urandom_range(99) < send_idle)
        begin
            attr_in.valid <= 1'b0;
            @(negedge clk);
        end
        attr_in.valid       <= 1'b1;
        attr_in.raw_comp_0  <= raw[0];
        attr_in.raw_comp_1  <= raw[1];
        attr_in.raw_comp_2  <= raw[2];
        attr_in.raw_comp_3  <= raw[3];
        attr_in.last_vertex <= last;
        do
        begin
            @(posedge clk);
        end
        while (!attr_in.ready);
        pending_vertices = {pending_vertices, res};
        @(negedge clk);
    endtask

    task automatic add_row(logic [2:0] dt, logic [2:0] nm, logic [2:0] cnt, logic [2:0] kind,
                           logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                           logic [31:0] r3, logic last, bit typed,
                           logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                           logic [31:0] e3, logic [31:0] epk);
        stim_row_t s;
        s.dt = dt; s.nm = nm; s.cnt = cnt; s.kind = kind;
        s.raw  = {r3, r2, r1, r0};
        s.last = last;
        s.typed = typed;
        s.res.vals = {e3, e2, e1, e0};
        s.res.packed_word = epk;
        s.res.last = last;
        stim_rows = {stim_rows, s};
    endtask

    // Random component, biased towards the interesting float ranges
    function automatic logic [31:0] random_raw();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(5))
            0: return w;
            1: return {w[31], 8'($urandom_range(100, 160)), w[22:0]};
            2:
            begin
                case ($urandom_range(5))
                    0: return {w[31], 31'd0};
                    1: return {w[31], 8'hFF, 23'd0};
                    2: return {w[31], 8'hFF, w[22:1], 1'b1};
                    3: return {w[31], 8'h00, w[22:0]};
                    4: return {w[31], 8'd158, w[22:0]};
                    default: return {w[31], 8'd157, 23'h7FFFFF};
                endcase
            end
            3: return {w[31:16], 16'($urandom_range(0, 300)) ^ {16{w[0]}}};
            4: return {w[31], 8'($urandom_range(0, 20)), w[22:0]};
            default: return w;
        endcase
    endfunction

    initial
    begin
        logic [3:0][31:0] raw;
        logic [2:0]       rdt;
        logic [2:0]       rkind;
        logic [2:0]       rcnt;
        logic             last;
        stim_row_t        s;
        error_count = 0;
        cycle_count = 0;
        send_idle = 0;
        recv_idle = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = vac_pkg::REG_DATA_TYPE;
        cfg_wdata = '0;
        attr_in.valid = 1'b0;
        attr_in.raw_comp_0 = '0;
        attr_in.raw_comp_1 = '0;
        attr_in.raw_comp_2 = '0;
        attr_in.raw_comp_3 = '0;
        attr_in.last_vertex = 1'b0;
        attr_out.ready = 1'b0;
        cur_type  = vac_pkg::DT_FLOAT;
        cur_norm  = 1'b0;
        cur_count = 3'd4;
        cur_kind  = vac_pkg::KIND_POSITION;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows; the first runs on the register values after reset
        add_row(vac_pkg::DT_FLOAT, 0, 4, vac_pkg::KIND_POSITION,
                32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 32'h7F80_0000, 0, 1,
                32'h3F80_0000, 32'h4000_0000, 32'hC040_0000, 0, 0);
        add_row(vac_pkg::DT_UBYTE, 1, 4, vac_pkg::KIND_COLOUR,
                32'hFF, 32'h00, 32'h80, 32'h7F, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_BYTE, 1, 4, vac_pkg::KIND_COLOUR,
                32'hFFFF_FF80, 32'h7F, 32'h00, 32'hFF, 0, 1,
                32'hBF80_0000, 32'h3F7E_0000, 0, 32'hBC00_0000, 0);
        add_row(vac_pkg::DT_SHORT, 1, 4, vac_pkg::KIND_WEIGHT,
                32'h8000, 32'h7FFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_USHORT, 1, 4, vac_pkg::KIND_WEIGHT,
                32'hFFFF, 0, 32'h8000, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_USHORT, 0, 4, vac_pkg::KIND_COLOUR,
                32'hFFFF, 32'hABCD_0001, 32'h8000, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_SHORT, 0, 4, vac_pkg::KIND_NORMAL,
                32'h8000, 32'h7FFF, 32'hFFFF, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 4, vac_pkg::KIND_TEXCOORD,
                32'h7F80_0001, 32'h7F80_0000, 32'h1234_5678, 32'h3F80_0000, 0, 1,
                32'h7FC0_0001, 32'h7F80_0000, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 4, vac_pkg::KIND_TEXCOORD,
                32'h0080_0000, 32'h8000_0001, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 4, vac_pkg::KIND_TEXCOORD,
                32'h3F80_0000, 32'h0100_0003, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 4, vac_pkg::KIND_BONE,
                32'h4F00_0000, 32'hCF00_0001, 32'h7FC0_0000, 32'h3FC0_0000, 0, 1,
                0, 0, 0, 0, 32'h7FFF_FFFF);
        add_row(vac_pkg::DT_FLOAT, 0, 4, vac_pkg::KIND_BONE,
                32'hBFC0_0000, 32'h4040_0000, 32'hFF80_0000, 32'hCF00_0000, 0, 0,
                0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_BYTE, 0, 4, vac_pkg::KIND_BONE,
                32'h80, 32'h7F, 32'h05, 32'hFE, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 0, vac_pkg::KIND_COLOUR,
                32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 0, 1,
                0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 7, vac_pkg::KIND_COLOUR,
                32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000, 0, 0,
                0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_UBYTE, 1, 1, vac_pkg::KIND_POSITION,
                32'h40, 32'h40, 32'h40, 32'h40, 0, 0, 0, 0, 0, 0, 0);
        add_row(3'd5, 0, 4, vac_pkg::KIND_COLOUR,
                32'h3F80_0000, 1, 2, 3, 0, 1, 0, 0, 0, 0, 0);
        add_row(3'd7, 1, 4, vac_pkg::KIND_COLOUR,
                32'hFFFF_FFFF, 1, 2, 3, 0, 1, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 1, 4, vac_pkg::KIND_WEIGHT,
                32'h3F80_0000, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_FLOAT, 0, 4, 3'd6,
                32'h3F80_0000, 1, 2, 3, 1, 1, 0, 0, 0, 0, 0);
        add_row(vac_pkg::DT_USHORT, 1, 3, 3'd7,
                32'hFFFF, 1, 2, 3, 1, 1, 0, 0, 0, 0, 0);

        foreach (stim_rows[i])
        begin
            s = stim_rows[i];
            if (i > 0 && {s.dt, s.nm[0], s.cnt, s.kind}
                         != {cur_type, cur_norm, cur_count, cur_kind})
            begin
                apply_setup(s.dt, s.nm, s.cnt, s.kind);
            end
            if (!s.typed)
            begin
                s.res = convert_vertex(s.raw, s.last);
            end
            send_vertex(s.raw, s.last, s.res);
        end

        // Random phases under three idling patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 15 : (mode == 1) ? 77 : 0;
            recv_idle = (mode == 0) ? 77 : (mode == 1) ? 15 : 0;
            for (int p = 0; p < 9; p++)
            begin
                rdt   = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
                rkind = ($urandom_range(9) < 8) ? 3'($urandom_range(5)) : 3'($urandom_range(6, 7));
                rcnt  = ($urandom_range(9) < 7) ? 3'($urandom_range(1, 4)) : 3'($urandom);
                apply_setup(rdt, 3'($urandom), rcnt, rkind);
                for (int k = 0; k < 61; k++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        raw[j] = random_raw();
                    end
                    last = (k == 60) || ($urandom_range(15) == 0);
                    send_vertex(raw, last, convert_vertex(raw, last));
                end
            end
        end
        attr_in.valid <= 1'b0;

        // Wait for the tail of the pipeline
        while (pending_vertices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
